// File: sv/u16sgd_pkg.sv
// shared types and constants of the utf16 string group deframer
`default_nettype none

package u16sgd_pkg;

  localparam int unsigned MaxStrings = 128;

  typedef enum logic [1:0] {
    KindChar  = 2'd0,
    KindEmpty = 2'd1,
    KindError = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ErrNone     = 2'd0,
    ErrOverrun  = 2'd1,
    ErrTooMany  = 2'd2,
    ErrZeroLen  = 2'd3
  } err_e;

  typedef enum logic [6:0] {
    PhHdrLo     = 7'b0000001,
    PhHdrHi     = 7'b0000010,
    PhLenFirst  = 7'b0000100,
    PhLenSecond = 7'b0001000,
    PhCharLo    = 7'b0010000,
    PhCharHi    = 7'b0100000,
    PhSkip      = 7'b1000000
  } phase_e;

  typedef struct packed {
    kind_e       kind;
    err_e        error_code;
    logic [15:0] char_code;
    logic [6:0]  string_index;
    logic [14:0] char_position;
    logic [15:0] dest_offset;
    logic        end_of_string;
    logic        end_of_group;
    logic [7:0]  group_strings;
    logic [14:0] group_chars;
  } result_t;

endpackage

`default_nettype wire

// File: sv/u16sgd_core.sv
// framing state and per-byte decode of the string deframer
`default_nettype none

module u16sgd_core (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic              cfg_wdata_i,
  input  wire logic              step_i,
  input  wire logic [7:0]        data_byte_i,
  output logic                   res_valid_o,
  output u16sgd_pkg::result_t    res_o
);

  logic                 gm_q, gm_d;
  u16sgd_pkg::phase_e   phase_q, phase_d;
  logic [15:0]          gbl_q, gbl_d, gbl_n;
  logic [14:0]          scl_q, scl_d, scl_n;
  logic [7:0]           held_q, held_d;
  logic [7:0]           sc_q, sc_d, sc_base;
  logic [14:0]          cc_q, cc_d;
  logic [15:0]          off_q, off_d, off_base;
  logic [14:0]          tot_q, tot_d, tot_base;
  logic                 start_req, err_req;
  logic [14:0]          len;
  u16sgd_pkg::err_e     err_code;
  logic                 after_hdr;

  always_comb begin
    gm_d        = gm_q;
    phase_d     = phase_q;
    gbl_d       = gbl_q;
    scl_d       = scl_q;
    held_d      = held_q;
    sc_d        = sc_q;
    cc_d        = cc_q;
    off_d       = off_q;
    tot_d       = tot_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    start_req   = 1'b0;
    err_req     = 1'b0;
    len         = '0;
    err_code    = u16sgd_pkg::ErrNone;
    scl_n       = scl_q - 15'd1;
    sc_base     = gm_q ? sc_q : 8'd0;
    off_base    = gm_q ? off_q : 16'd0;
    tot_base    = gm_q ? tot_q : 15'd0;

    gbl_n = gbl_q;
    if (gm_q && phase_q != u16sgd_pkg::PhHdrLo && phase_q != u16sgd_pkg::PhHdrHi &&
        gbl_q != 16'd0) begin
      gbl_n = gbl_q - 16'd1;
    end
    after_hdr = gm_q && (gbl_n == 16'd0);

    if (step_i) begin
      gbl_d = gbl_n;
      case (phase_q)
        u16sgd_pkg::PhHdrLo: begin
          held_d  = data_byte_i;
          phase_d = u16sgd_pkg::PhHdrHi;
        end
        u16sgd_pkg::PhHdrHi: begin
          gbl_d = {data_byte_i, held_q};
          sc_d  = '0;
          off_d = '0;
          tot_d = '0;
          if ({data_byte_i, held_q} == 16'd0) begin
            err_req  = 1'b1;
            err_code = u16sgd_pkg::ErrZeroLen;
          end else begin
            phase_d = u16sgd_pkg::PhLenFirst;
          end
        end
        u16sgd_pkg::PhLenFirst: begin
          if (data_byte_i[7]) begin
            if (after_hdr) begin
              err_req  = 1'b1;
              err_code = u16sgd_pkg::ErrOverrun;
            end else begin
              held_d  = {1'b0, data_byte_i[6:0]};
              phase_d = u16sgd_pkg::PhLenSecond;
            end
          end else begin
            start_req = 1'b1;
            len       = {8'd0, data_byte_i[6:0]};
          end
        end
        u16sgd_pkg::PhLenSecond: begin
          start_req = 1'b1;
          len       = {held_q[6:0], data_byte_i};
        end
        u16sgd_pkg::PhCharLo: begin
          held_d  = data_byte_i;
          phase_d = u16sgd_pkg::PhCharHi;
        end
        u16sgd_pkg::PhCharHi: begin
          tot_d       = tot_q + 15'd1;
          scl_d       = scl_n;
          cc_d        = cc_q + 15'd1;
          res_valid_o = 1'b1;
          res_o.kind          = u16sgd_pkg::KindChar;
          res_o.error_code    = u16sgd_pkg::ErrNone;
          res_o.char_code     = {data_byte_i, held_q};
          res_o.string_index  = 7'(sc_q - 8'd1);
          res_o.char_position = cc_q;
          res_o.dest_offset   = off_q;
          res_o.end_of_string = (scl_n == 15'd0);
          res_o.end_of_group  = (scl_n == 15'd0) && after_hdr;
          res_o.group_strings = sc_q;
          res_o.group_chars   = tot_q + 15'd1;
          if (scl_n == 15'd0) begin
            off_d   = off_q + 16'(cc_q + 15'd1) + 16'd1;
            phase_d = after_hdr ? u16sgd_pkg::PhHdrLo : u16sgd_pkg::PhLenFirst;
          end else begin
            phase_d = u16sgd_pkg::PhCharLo;
          end
        end
        u16sgd_pkg::PhSkip: begin
          if (gbl_n == 16'd0) begin
            phase_d = u16sgd_pkg::PhHdrLo;
          end
        end
        default: begin
          phase_d = gm_q ? u16sgd_pkg::PhHdrLo : u16sgd_pkg::PhLenFirst;
          gbl_d   = '0;
          scl_d   = '0;
          held_d  = '0;
          sc_d    = '0;
          cc_d    = '0;
          off_d   = '0;
          tot_d   = '0;
        end
      endcase

      if (start_req) begin
        if (gm_q && sc_q >= 8'(u16sgd_pkg::MaxStrings)) begin
          err_req  = 1'b1;
          err_code = u16sgd_pkg::ErrTooMany;
        end else if (gm_q && {1'b0, len, 1'b0} > {1'b0, gbl_n}) begin
          err_req  = 1'b1;
          err_code = u16sgd_pkg::ErrOverrun;
        end else begin
          sc_d  = sc_base + 8'd1;
          cc_d  = '0;
          scl_d = len;
          off_d = off_base;
          tot_d = tot_base;
          if (len == 15'd0) begin
            res_valid_o = 1'b1;
            res_o.kind          = u16sgd_pkg::KindEmpty;
            res_o.error_code    = u16sgd_pkg::ErrNone;
            res_o.string_index  = 7'(sc_base);
            res_o.dest_offset   = off_base;
            res_o.end_of_string = 1'b1;
            res_o.end_of_group  = after_hdr;
            res_o.group_strings = sc_base + 8'd1;
            res_o.group_chars   = tot_base;
            off_d   = off_base + 16'd1;
            phase_d = after_hdr ? u16sgd_pkg::PhHdrLo : u16sgd_pkg::PhLenFirst;
          end else begin
            phase_d = u16sgd_pkg::PhCharLo;
          end
        end
      end

      if (err_req) begin
        res_valid_o      = 1'b1;
        res_o            = '0;
        res_o.kind       = u16sgd_pkg::KindError;
        res_o.error_code = err_code;
        phase_d = (gbl_d == 16'd0) ? u16sgd_pkg::PhHdrLo : u16sgd_pkg::PhSkip;
      end
    end

    if (cfg_we_i) begin
      gm_d    = cfg_wdata_i;
      phase_d = cfg_wdata_i ? u16sgd_pkg::PhHdrLo : u16sgd_pkg::PhLenFirst;
      gbl_d   = '0;
      scl_d   = '0;
      held_d  = '0;
      sc_d    = '0;
      cc_d    = '0;
      off_d   = '0;
      tot_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gm_q    <= 1'b1;
      phase_q <= u16sgd_pkg::PhHdrLo;
      gbl_q   <= '0;
      scl_q   <= '0;
      held_q  <= '0;
      sc_q    <= '0;
      cc_q    <= '0;
      off_q   <= '0;
      tot_q   <= '0;
    end else begin
      gm_q    <= gm_d;
      phase_q <= phase_d;
      gbl_q   <= gbl_d;
      scl_q   <= scl_d;
      held_q  <= held_d;
      sc_q    <= sc_d;
      cc_q    <= cc_d;
      off_q   <= off_d;
      tot_q   <= tot_d;
    end
  end

endmodule

`default_nettype wire

// File: sv/utf16_string_group_deframer.sv
// Top level of the UTF-16 string group deframer. One data byte is taken per
// cycle while in_stall_o is low and gives at most one result; the result
// is registered in a result register backed by a one-entry skid stage, so
// in_stall_o is a registered signal, raised only while the skid stage holds
// a result. The sustained rate is one byte per cycle while out_stall_i is
// low, set by the single decode step between the framing state and the
// result register. A write to the group mode register restarts framing.
`default_nettype none

module utf16_string_group_deframer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  data_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       kind_o,
  output logic [1:0]       error_code_o,
  output logic [15:0]      char_code_o,
  output logic [6:0]       string_index_o,
  output logic [14:0]      char_position_o,
  output logic [15:0]      dest_offset_o,
  output logic             end_of_string_o,
  output logic             end_of_group_o,
  output logic [7:0]       group_strings_o,
  output logic [14:0]      group_chars_o
);

  logic                 step;
  logic                 res_valid;
  u16sgd_pkg::result_t  res;
  logic                 drain;
  logic                 out_v_q, out_v_d;
  logic                 skid_v_q, skid_v_d;
  u16sgd_pkg::result_t  out_q, out_d;
  u16sgd_pkg::result_t  skid_q, skid_d;

  assign in_stall_o = skid_v_q;
  assign step       = in_valid_i && !skid_v_q;
  assign drain      = out_v_q && !out_stall_i;

  u16sgd_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .step_i      (step),
    .data_byte_i (data_byte_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_comb begin
    out_v_d  = out_v_q;
    skid_v_d = skid_v_q;
    out_d    = out_q;
    skid_d   = skid_q;
    if (skid_v_q) begin
      if (drain) begin
        out_d    = skid_q;
        skid_v_d = 1'b0;
      end
    end else if (step && res_valid) begin
      if (!out_v_q || drain) begin
        out_d   = res;
        out_v_d = 1'b1;
      end else begin
        skid_d   = res;
        skid_v_d = 1'b1;
      end
    end else if (drain) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o     = out_v_q;
  assign kind_o          = out_q.kind;
  assign error_code_o    = out_q.error_code;
  assign char_code_o     = out_q.char_code;
  assign string_index_o  = out_q.string_index;
  assign char_position_o = out_q.char_position;
  assign dest_offset_o   = out_q.dest_offset;
  assign end_of_string_o = out_q.end_of_string;
  assign end_of_group_o  = out_q.end_of_group;
  assign group_strings_o = out_q.group_strings;
  assign group_chars_o   = out_q.group_chars;

endmodule

`default_nettype wire

// File: sv/u16sgd_checker.sv
// port-level assertions for the string deframer, bound to the top level
`default_nettype none

module u16sgd_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_wdata_i,
  input  wire logic        in_valid_i,
  input  wire logic        in_stall_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        out_valid_o,
  input  wire logic        out_stall_i,
  input  wire logic [1:0]  kind_o,
  input  wire logic [1:0]  error_code_o,
  input  wire logic [15:0] char_code_o,
  input  wire logic [6:0]  string_index_o,
  input  wire logic [14:0] char_position_o,
  input  wire logic [15:0] dest_offset_o,
  input  wire logic        end_of_string_o,
  input  wire logic        end_of_group_o,
  input  wire logic [7:0]  group_strings_o,
  input  wire logic [14:0] group_chars_o
);

  // stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // stalled result payload does not move
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(kind_o) && $stable(char_code_o) &&
      $stable(dest_offset_o) && $stable(group_chars_o))
    else $error("stalled result changed");

  // error results carry a code and nothing else
  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == u16sgd_pkg::KindError |->
      error_code_o != u16sgd_pkg::ErrNone && char_code_o == 16'd0 &&
      group_strings_o == 8'd0 && end_of_string_o == 1'b0 && end_of_group_o == 1'b0)
    else $error("malformed error result");

  // group end only closes a string
  a_eog_eos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && end_of_group_o |-> end_of_string_o)
    else $error("group end without string end");

  // characters belong to a counted string
  a_char_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == u16sgd_pkg::KindChar |->
      error_code_o == u16sgd_pkg::ErrNone && group_strings_o != 8'd0 &&
      group_chars_o != 15'd0)
    else $error("character result outside a string");

endmodule

bind utf16_string_group_deframer u16sgd_checker u_checker (.*);

`default_nettype wire
